// File: src/lmbcs_pkg.sv
package lmbcs_pkg;

  // Decoder sequence state carried from byte to byte
  typedef struct packed {
    logic [7:0] lead_class;
    logic [1:0] bytes_pending;
    logic [7:0] first_trail;
    logic       terminated;
  } seq_state_t;

  // Result of decoding one byte
  typedef struct packed {
    logic [15:0] code_point;
    logic        char_valid;
  } dec_result_t;

  localparam logic [7:0]  LEAD_END    = 8'h00;
  localparam logic [7:0]  LEAD_GRP1   = 8'h01;
  localparam logic [7:0]  LEAD_UCS    = 8'h14;
  localparam logic [7:0]  LEAD_TWO_LO = 8'h10;
  localparam logic [7:0]  LEAD_TWO_HI = 8'h17;
  localparam logic [7:0]  LEAD_ONE_LO = 8'h18;
  localparam logic [7:0]  LEAD_ONE_HI = 8'h1F;
  localparam logic [7:0]  CTRL_LO     = 8'h02;
  localparam logic [7:0]  CTRL_HI     = 8'h0F;
  localparam logic [7:0]  CHAR_TAB    = 8'h09;
  localparam logic [7:0]  CHAR_LF     = 8'h0A;
  localparam logic [7:0]  CHAR_CR     = 8'h0D;
  localparam logic [7:0]  ASCII_MAX   = 8'h7F;
  localparam logic [15:0] PUA_LO      = 16'hE000;
  localparam logic [15:0] PUA_HI      = 16'hF8FF;

  // Group-1 code page, indexed by byte value
  localparam logic [15:0] GRP1_ROM [256] = '{
    16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
    16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
    16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
    16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC,
    16'h00A8, 16'h007E, 16'h02DA, 16'h005E, 16'h0060, 16'h00B4, 16'h201C, 16'h0027,
    16'h2026, 16'h2013, 16'h2014, 16'h2018, 16'h2019, 16'h0000, 16'h2039, 16'h203A,
    16'h00A8, 16'h007E, 16'h02DA, 16'h005E, 16'h0060, 16'h00B4, 16'h201E, 16'h201A,
    16'h201D, 16'h2017, 16'h0000, 16'h00A0, 16'h0000, 16'hFFFD, 16'h0000, 16'h0000,
    16'h0152, 16'h0153, 16'h0178, 16'h02D9, 16'h02DA, 16'h0000, 16'h255E, 16'h255F,
    16'h258C, 16'h2590, 16'h25CA, 16'h2318, 16'hF8FF, 16'hF8FE, 16'h2126, 16'h0000,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2561, 16'h2562, 16'h2556, 16'h2555, 16'h255C, 16'h255B, 16'h2567,
    16'h0133, 16'h0132, 16'hF8FD, 16'hF8FC, 16'h0149, 16'h0140, 16'h013F, 16'h00AF,
    16'h02D8, 16'h02DD, 16'h02DB, 16'h02C7, 16'h007E, 16'h005E, 16'h0000, 16'h0000,
    16'h2020, 16'h2021, 16'h0126, 16'h0127, 16'h0166, 16'h0167, 16'h2122, 16'h2113,
    16'h014A, 16'h014B, 16'h0138, 16'h0000, 16'hF8FB, 16'h2310, 16'h20A4, 16'h20A7,
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00F8, 16'h00A3, 16'h00D8, 16'h00D7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h00AE, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h00C1, 16'h00C2, 16'h00C0,
    16'h00A9, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h00A2, 16'h00A5, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h00E3, 16'h00C3,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h00A4,
    16'h00F0, 16'h00D0, 16'h00CA, 16'h00CB, 16'h00C8, 16'h0131, 16'h00CD, 16'h00CE,
    16'h00CF, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h00A6, 16'h00CC, 16'h2580,
    16'h00D3, 16'h00DF, 16'h00D4, 16'h00D2, 16'h00F5, 16'h00D5, 16'h00B5, 16'h00FE,
    16'h00DE, 16'h00DA, 16'h00DB, 16'h00D9, 16'h00FD, 16'h00DD, 16'h00AF, 16'h00B4,
    16'h00AD, 16'h00B1, 16'h2017, 16'h00BE, 16'h00B6, 16'h00A7, 16'h00F7, 16'h00B8,
    16'h00B0, 16'h00A8, 16'h00B7, 16'h00B9, 16'h00B3, 16'h00B2, 16'h25A0, 16'h00A0
  };

endpackage

// File: src/lmbcs_decode.sv
// Byte classifier, table lookup and next-state logic for one byte.
module lmbcs_decode (
  input  logic [7:0]              in_byte,
  input  logic                    last_byte,
  input  lmbcs_pkg::seq_state_t   state,
  output lmbcs_pkg::seq_state_t   state_next,
  output lmbcs_pkg::dec_result_t  result
);

  logic [1:0]  pend_dec;
  logic [15:0] rom_val;
  logic [15:0] ucs_val;
  logic [15:0] cp;
  logic        valid;
  logic        is_skip1;
  logic        is_two;

  assign pend_dec = state.bytes_pending - 2'd1;
  assign rom_val  = lmbcs_pkg::GRP1_ROM[in_byte];
  assign ucs_val  = {state.first_trail, in_byte};

  assign is_two   = (in_byte >= lmbcs_pkg::LEAD_TWO_LO) && (in_byte <= lmbcs_pkg::LEAD_TWO_HI);
  assign is_skip1 = ((in_byte >= lmbcs_pkg::CTRL_LO) && (in_byte <= lmbcs_pkg::CTRL_HI) &&
                     (in_byte != lmbcs_pkg::CHAR_TAB) && (in_byte != lmbcs_pkg::CHAR_LF) &&
                     (in_byte != lmbcs_pkg::CHAR_CR)) ||
                    ((in_byte >= lmbcs_pkg::LEAD_ONE_LO) && (in_byte <= lmbcs_pkg::LEAD_ONE_HI));

  always_comb begin
    state_next = state;
    cp         = '0;
    valid      = 1'b0;
    if (state.terminated) begin
      // string ended, wait for the final byte
    end else if (state.bytes_pending != 2'd0) begin
      state_next.bytes_pending = pend_dec;
      if (state.lead_class == lmbcs_pkg::LEAD_GRP1) begin
        cp    = rom_val;
        valid = (rom_val != 16'h0000);
      end else if (state.lead_class == lmbcs_pkg::LEAD_UCS) begin
        if (pend_dec != 2'd0) begin
          state_next.first_trail = in_byte;
        end else begin
          cp    = ucs_val;
          valid = !((ucs_val >= lmbcs_pkg::PUA_LO) && (ucs_val <= lmbcs_pkg::PUA_HI));
        end
      end
      if (pend_dec == 2'd0) begin
        state_next.lead_class = '0;
      end
    end else if (in_byte == lmbcs_pkg::LEAD_END) begin
      state_next.terminated = 1'b1;
    end else if (in_byte == lmbcs_pkg::LEAD_GRP1 || is_skip1) begin
      state_next.lead_class    = in_byte;
      state_next.bytes_pending = 2'd1;
    end else if (is_two) begin
      state_next.lead_class    = in_byte;
      state_next.bytes_pending = 2'd2;
    end else if (in_byte <= lmbcs_pkg::ASCII_MAX) begin
      cp    = {8'h00, in_byte};
      valid = 1'b1;
    end else begin
      cp    = rom_val;
      valid = (rom_val != 16'h0000);
    end

    // final byte drops any open sequence and rearms for the next string
    if (last_byte) begin
      state_next = '0;
    end

    result.code_point = valid ? cp : 16'h0000;
    result.char_valid = valid;
  end

endmodule

// File: src/lmbcs_byte_stream_decoder.sv
// An accepted byte is held in the input register, decoded, and loaded into the result
// register once that register can advance; the result can be taken from there.
// Throughput: one byte per cycle unless out_stall holds; each byte is decoded in a
// single pass from input to result register; sequence state updates in the same cycle.
// Reset (rst, synchronous): empties both stages and clears the sequence state, so the
// next byte is taken as the start of a new string.
module lmbcs_byte_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_point,
  output logic        char_valid,
  output logic        end_of_string
);

  // Input register stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Sequence state across bytes (lead byte, trailing count, saved trail, terminated)
  lmbcs_pkg::seq_state_t  state;
  lmbcs_pkg::seq_state_t  state_next;
  lmbcs_pkg::dec_result_t dec;

  // Result register loads when empty or when its request is taken this cycle.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  // Input stage holds only while its byte cannot move into the result register.
  assign in_stall = s1_valid && !adv;

  lmbcs_decode u_decode (
    .in_byte    (s1_byte),
    .last_byte  (s1_last),
    .state      (state),
    .state_next (state_next),
    .result     (dec)
  );

  // Control: stage valids and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          state <= state_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= in_byte;
      s1_last <= last_byte;
    end
    if (adv && s1_valid) begin
      code_point    <= dec.code_point;
      char_valid    <= dec.char_valid;
      end_of_string <= s1_last;
    end
  end

endmodule

// File: tb/sv/tb_lmbcs_byte_stream_decoder.sv
`timescale 1ns / 1ps

module tb_lmbcs_byte_stream_decoder;

  // Run length: stimulus stops once this many requests have gone in.
  localparam int TOTAL_REQUESTS = 950;
  // Each request may wait out random idling on each side plus its passage through the
  // two-stage pipe, so the limit is a generous bound for the whole run.
  localparam int CYCLE_LIMIT    = 200000;
  // Cycles to keep watching for stray results after the last one arrived.
  localparam int DRAIN_CYCLES   = 40;

  // Directed requests, {last_byte, in_byte}.
  localparam int N_DIRECTED = 27;
  localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
    9'h041, 9'h00D, 9'h07F,          // plain ASCII, CR control, top of ASCII
    9'h0FF,                          // high byte via table
    9'h001, 9'h000,                  // group-1 lead, zero table entry
    9'h001, 9'h0FF,                  // group-1 lead, top entry
    9'h014, 9'h0E0, 9'h000,          // UCS at bottom of private use: dropped
    9'h014, 9'h0F8, 9'h0FF,          // UCS at top of private use: dropped
    9'h014, 9'h000, 9'h000,          // UCS giving code point zero: kept
    9'h010, 9'h000, 9'h014,          // two-byte skip; trail bytes never lead
    9'h002, 9'h001,                  // one-byte skip
    9'h014, 9'h112,                  // UCS cut off by end of string
    9'h000, 9'h041, 9'h101           // terminator, then bytes ignored to end
  };

  typedef struct packed {
    logic [15:0] cp;
    logic        valid;
    logic        eos;
  } decoded_char_t;

  // Tracks decoder state per request and holds the characters still owed.
  class decode_tracker;
    logic [7:0]    open_lead;
    logic [1:0]    trail_left;
    logic [7:0]    ucs_high;
    logic          ended;
    decoded_char_t expected_chars[$];
    int            mismatches;
    int            checked;

    function new();
      clear();
      mismatches = 0;
      checked    = 0;
    endfunction

    function void clear();
      open_lead  = '0;
      trail_left = '0;
      ucs_high   = '0;
      ended      = 1'b0;
    endfunction

    function decoded_char_t decode_byte(logic [7:0] raw, logic last);
      decoded_char_t res;
      logic [15:0]   cp;
      logic          ok;
      cp = '0;
      ok = 1'b0;
      if (ended) begin
        // string terminated: swallow until the final byte
      end else if (trail_left != 0) begin
        trail_left = trail_left - 2'd1;
        if (open_lead == lmbcs_pkg::LEAD_GRP1) begin
          cp = lmbcs_pkg::GRP1_ROM[raw];
          ok = (cp != 0);
        end else if (open_lead == lmbcs_pkg::LEAD_UCS) begin
          if (trail_left != 0) begin
            ucs_high = raw;
          end else begin
            cp = {ucs_high, raw};
            ok = !(cp >= lmbcs_pkg::PUA_LO && cp <= lmbcs_pkg::PUA_HI);
          end
        end
        if (trail_left == 0) open_lead = '0;
      end else if (raw == lmbcs_pkg::LEAD_END) begin
        ended = 1'b1;
      end else if (raw == lmbcs_pkg::LEAD_GRP1) begin
        open_lead  = raw;
        trail_left = 2'd1;
      end else if (raw >= lmbcs_pkg::LEAD_TWO_LO && raw <= lmbcs_pkg::LEAD_TWO_HI) begin
        open_lead  = raw;
        trail_left = 2'd2;
      end else if ((raw >= lmbcs_pkg::CTRL_LO && raw <= lmbcs_pkg::CTRL_HI &&
                    raw != lmbcs_pkg::CHAR_TAB && raw != lmbcs_pkg::CHAR_LF &&
                    raw != lmbcs_pkg::CHAR_CR) ||
                   (raw >= lmbcs_pkg::LEAD_ONE_LO && raw <= lmbcs_pkg::LEAD_ONE_HI)) begin
        open_lead  = raw;
        trail_left = 2'd1;
      end else if (raw <= lmbcs_pkg::ASCII_MAX) begin
        cp = {8'h00, raw};
        ok = 1'b1;
      end else begin
        cp = lmbcs_pkg::GRP1_ROM[raw];
        ok = (cp != 0);
      end
      if (!ok) cp = '0;
      res.cp    = cp;
      res.valid = ok;
      res.eos   = last;
      if (last) clear();
      return res;
    endfunction

    function void note_request(logic [7:0] raw, logic last);
      expected_chars.push_back(decode_byte(raw, last));
    endfunction

    task report_mismatch(string msg);
      $display("%0t: result %0d: %s", $time, checked, msg);
      mismatches++;
    endtask

    task check_char(logic [15:0] cp, logic valid, logic eos);
      decoded_char_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_chars.pop_front();
        if (cp !== want.cp)
          report_mismatch($sformatf("code_point %h, want %h", cp, want.cp));
        if (valid !== want.valid)
          report_mismatch($sformatf("char_valid %b, want %b", valid, want.valid));
        if (eos !== want.eos)
          report_mismatch($sformatf("end_of_string %b, want %b", eos, want.eos));
      end
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] code_point;
  logic        char_valid;
  logic        end_of_string;

  decode_tracker sb;
  int            requests_sent = 0;
  int            cycle_count   = 0;
  // Quiet mode switches idling off for a stretch on that side.
  bit            send_quiet    = 1'b0;
  bit            recv_quiet    = 1'b0;

  lmbcs_byte_stream_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_point    (code_point),
    .char_valid    (char_valid),
    .end_of_string (end_of_string)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one byte, hold it until the decoder takes it, then log it.
  // Returns at the edge of acceptance so back-to-back requests keep valid high.
  task automatic send_request(input logic [7:0] raw, input logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= raw;
    last_byte <= last;
    do @(posedge clk); while (in_stall);
    sb.note_request(raw, last);
    requests_sent++;
  endtask

  // Output side: stall for a random hold before each result, then take it.
  task automatic drain_results();
    int hold;
    forever begin
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      hold = recv_quiet ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      sb.check_char(code_point, char_valid, end_of_string);
    end
  endtask

  // Append one well-formed token (or a bit of noise) to the string under
  // construction. Trail bytes take any value, zero included.
  function automatic void append_token(ref logic [7:0] text[$]);
    logic [7:0] b;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0:       b = lmbcs_pkg::CHAR_TAB;
            1:       b = lmbcs_pkg::CHAR_LF;
            default: b = lmbcs_pkg::CHAR_CR;
          endcase
        end else begin
          b = 8'($urandom_range(8'h20, lmbcs_pkg::ASCII_MAX));
        end
        text.push_back(b);
      end
      5, 6, 7: begin
        b = 8'($urandom_range(8'h80, 8'hFF));
        text.push_back(b);
      end
      8, 9, 10: begin
        text.push_back(lmbcs_pkg::LEAD_GRP1);
        b = 8'($urandom_range(0, 255));
        text.push_back(b);
      end
      11, 12, 13: begin
        // bias the high byte toward the private-use edges
        text.push_back(lmbcs_pkg::LEAD_UCS);
        if ($urandom_range(0, 2) == 0) b = 8'($urandom_range(8'hDF, 8'hF9));
        else b = 8'($urandom_range(0, 255));
        text.push_back(b);
        b = 8'($urandom_range(0, 255));
        text.push_back(b);
      end
      14, 15: begin
        do b = 8'($urandom_range(lmbcs_pkg::CTRL_LO, lmbcs_pkg::LEAD_ONE_HI));
        while ((b >= lmbcs_pkg::LEAD_TWO_LO && b <= lmbcs_pkg::LEAD_TWO_HI) ||
               b == lmbcs_pkg::CHAR_TAB || b == lmbcs_pkg::CHAR_LF ||
               b == lmbcs_pkg::CHAR_CR);
        text.push_back(b);
        b = 8'($urandom_range(0, 255));
        text.push_back(b);
      end
      16: begin
        do b = 8'($urandom_range(lmbcs_pkg::LEAD_TWO_LO, lmbcs_pkg::LEAD_TWO_HI));
        while (b == lmbcs_pkg::LEAD_UCS);
        text.push_back(b);
        b = 8'($urandom_range(0, 255));
        text.push_back(b);
        b = 8'($urandom_range(0, 255));
        text.push_back(b);
      end
      17: text.push_back(lmbcs_pkg::LEAD_END);
      default: begin
        b = 8'($urandom_range(0, 255));
        text.push_back(b);
      end
    endcase
  endfunction

  // Random strings: mostly short, some long. The string is cut at its
  // length, so an open sequence at the end gets truncated now and then.
  task automatic run_random();
    logic [7:0] text[$];
    int         len;
    while (requests_sent < TOTAL_REQUESTS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      text.delete();
      while (text.size() < len) append_token(text);
      for (int i = 0; i < len; i++) send_request(text[i], i == len - 1);
    end
  endtask

  initial begin
    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_byte   <= '0;
    last_byte <= 1'b0;
    out_stall <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    fork
      drain_results();
    join_none

    for (int i = 0; i < N_DIRECTED; i++)
      send_request(DIRECTED[i][7:0], DIRECTED[i][8]);
    run_random();
    in_valid <= 1'b0;

    // wait for every owed character, then watch a little longer for strays
    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: lmbcs_byte_stream_decoder.f
src/lmbcs_pkg.sv
src/lmbcs_decode.sv
src/lmbcs_byte_stream_decoder.sv
tb/sv/tb_lmbcs_byte_stream_decoder.sv
